/* sv/stsa_pkg.sv */
// Package for the sparse transpose scatter accumulator.
// Field widths, fixed-point format, saturation bounds and operation codes.
// No dependencies.
`default_nettype none

package stsa_pkg;

   localparam int COL_W       = 12;
   localparam int VAL_W       = 32;
   localparam int FRAC_W      = 16;
   localparam int PROD_W      = 2 * VAL_W;
   localparam int SUM_W       = 48;
   localparam int ENTRY_W     = SUM_W + 1;
   localparam int COLUMNS_DEF = 4096;

   localparam logic [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
   localparam logic [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

   typedef enum logic {
      OP_ACCUMULATE = 1'b0,
      OP_READ       = 1'b1
   } op_type;

endpackage

`default_nettype wire

/* sv/stsa_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
// A read at the address being written returns the old contents. No dependencies.
`default_nettype none

module stsa_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 16,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* sv/sparse_transpose_scatter_accumulate.sv */
// Sparse transpose scatter accumulator: top level, read-modify-write pipeline.
// Depends on stsa_pkg and stsa_ram.
//
// One word is taken per clock while busy is low. An accumulate word multiplies
// row_scale by matrix_value (Q16.16, product floored to Q.16) and adds it into
// the 48-bit saturating sum of its column; a read word returns that column's
// sum and sticky overflow flag on rsp_strobe, through the multiply stage, the
// write-back stage and the result register, and clears the entry. The result is
// shown for one cycle only: the receiver cannot stall it. The accumulator lives
// in one RAM with a registered read; back-to-back words on the same column are
// served by forwarding from the write stage and from the previous write. After
// reset the block runs a clearing pass over all COLUMNS entries, one entry a
// cycle, with busy high. Columns at or above COLUMNS are ignored on accumulate and read back as zero.
`default_nettype none

module sparse_transpose_scatter_accumulate #(
   parameter int COLUMNS = stsa_pkg::COLUMNS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic                                req_operation,
   input  logic [stsa_pkg::COL_W-1:0]          req_column,
   input  logic signed [stsa_pkg::VAL_W-1:0]   req_row_scale,
   input  logic signed [stsa_pkg::VAL_W-1:0]   req_matrix_value,
   output logic                                rsp_strobe,
   output logic [stsa_pkg::COL_W-1:0]          rsp_read_column,
   output logic signed [stsa_pkg::SUM_W-1:0]   rsp_column_sum,
   output logic                                rsp_overflowed
);

   import stsa_pkg::*;

   localparam int ADDR_W = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(COLUMNS - 1);

   // clearing pass
   logic              clearing_ff;
   logic [ADDR_W-1:0] clr_addr_ff;

   // stage 1: RAM read in flight, multiply
   logic                    s1_valid_ff;
   logic                    s1_read_ff;
   logic                    s1_in_range_ff;
   logic                    s1_zero_scale_ff;
   logic [COL_W-1:0]        s1_column_ff;
   logic [ADDR_W-1:0]       s1_addr_ff;
   logic signed [VAL_W-1:0] s1_scale_ff;
   logic signed [VAL_W-1:0] s1_value_ff;

   // stage 2: add, saturate, write back
   logic                    s2_valid_ff;
   logic                    s2_read_ff;
   logic                    s2_in_range_ff;
   logic                    s2_zero_scale_ff;
   logic [COL_W-1:0]        s2_column_ff;
   logic [ADDR_W-1:0]       s2_addr_ff;
   logic [SUM_W-1:0]        s2_prod_ff;
   logic [ENTRY_W-1:0]      s2_old_ff;

   // last item write, for the read issued in the same cycle
   logic                    lw_valid_ff;
   logic [ADDR_W-1:0]       lw_addr_ff;
   logic [ENTRY_W-1:0]      lw_data_ff;

   // result
   logic                    rsp_strobe_ff;
   logic [COL_W-1:0]        rsp_column_ff;
   logic [SUM_W-1:0]        rsp_sum_ff;
   logic                    rsp_ovf_ff;

   logic                    accept;
   logic                    req_in_range;
   logic [ADDR_W-1:0]       req_addr;
   logic signed [PROD_W-1:0] s1_prod;
   logic [ENTRY_W-1:0]      ram_rd_data;
   logic [ENTRY_W-1:0]      s1_old_in;
   logic [SUM_W:0]          s2_sum_wide;
   logic                    s2_ovf;
   logic [SUM_W-1:0]        s2_sum_sat;
   logic                    s2_wr_en;
   logic [ENTRY_W-1:0]      s2_wr_data;
   logic                    ram_wr_en;
   logic [ADDR_W-1:0]       ram_wr_addr;
   logic [ENTRY_W-1:0]      ram_wr_data;

   assign busy         = clearing_ff;
   assign accept       = start && !clearing_ff;
   assign req_in_range = 32'(req_column) < COLUMNS;
   assign req_addr     = ADDR_W'(req_column);

   assign s1_prod = s1_scale_ff * s1_value_ff;

   always_comb begin
      if (s2_wr_en && s2_addr_ff == s1_addr_ff) begin
         s1_old_in = s2_wr_data;
      end else if (lw_valid_ff && lw_addr_ff == s1_addr_ff) begin
         s1_old_in = lw_data_ff;
      end else begin
         s1_old_in = ram_rd_data;
      end
   end

   assign s2_sum_wide = {s2_old_ff[SUM_W-1], s2_old_ff[SUM_W-1:0]}
                      + {s2_prod_ff[SUM_W-1], s2_prod_ff};
   assign s2_ovf      = s2_sum_wide[SUM_W] != s2_sum_wide[SUM_W-1];
   assign s2_sum_sat  = s2_ovf ? (s2_sum_wide[SUM_W] ? SUM_MIN : SUM_MAX)
                               : s2_sum_wide[SUM_W-1:0];

   always_comb begin
      s2_wr_en   = 1'b0;
      s2_wr_data = '0;
      if (s2_valid_ff && s2_in_range_ff) begin
         if (s2_read_ff) begin
            s2_wr_en = 1'b1;
         end else if (!s2_zero_scale_ff) begin
            s2_wr_en   = 1'b1;
            s2_wr_data = {s2_old_ff[SUM_W] | s2_ovf, s2_sum_sat};
         end
      end
   end

   assign ram_wr_en   = clearing_ff || s2_wr_en;
   assign ram_wr_addr = clearing_ff ? clr_addr_ff : s2_addr_ff;
   assign ram_wr_data = clearing_ff ? '0 : s2_wr_data;

   stsa_ram #(
      .WIDTH  (ENTRY_W),
      .DEPTH  (COLUMNS),
      .ADDR_W (ADDR_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (accept),
      .rd_addr (req_addr),
      .rd_data (ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff   <= 1'b1;
         clr_addr_ff   <= '0;
         s1_valid_ff   <= 1'b0;
         s2_valid_ff   <= 1'b0;
         lw_valid_ff   <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         if (clearing_ff) begin
            clr_addr_ff <= clr_addr_ff + 1'b1;
            if (clr_addr_ff == LAST_ADDR) begin
               clearing_ff <= 1'b0;
            end
         end
         s1_valid_ff   <= accept;
         s2_valid_ff   <= s1_valid_ff;
         lw_valid_ff   <= s2_wr_en;
         rsp_strobe_ff <= s2_valid_ff && s2_read_ff;
      end

      s1_read_ff       <= req_operation == OP_READ;
      s1_in_range_ff   <= req_in_range;
      s1_zero_scale_ff <= req_row_scale == '0;
      s1_column_ff     <= req_column;
      s1_addr_ff       <= req_addr;
      s1_scale_ff      <= req_row_scale;
      s1_value_ff      <= req_matrix_value;

      s2_read_ff       <= s1_read_ff;
      s2_in_range_ff   <= s1_in_range_ff;
      s2_zero_scale_ff <= s1_zero_scale_ff;
      s2_column_ff     <= s1_column_ff;
      s2_addr_ff       <= s1_addr_ff;
      s2_prod_ff       <= s1_prod[PROD_W-1:FRAC_W];
      s2_old_ff        <= s1_old_in;

      lw_addr_ff       <= s2_addr_ff;
      lw_data_ff       <= s2_wr_data;

      rsp_column_ff    <= s2_column_ff;
      rsp_sum_ff       <= s2_in_range_ff ? s2_old_ff[SUM_W-1:0] : '0;
      rsp_ovf_ff       <= s2_in_range_ff && s2_old_ff[SUM_W];
   end

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_read_column = rsp_column_ff;
   assign rsp_column_sum  = rsp_sum_ff;
   assign rsp_overflowed  = rsp_ovf_ff;

endmodule

`default_nettype wire

/* tb/sv/tb_sparse_transpose_scatter_accumulate.sv */
// Self-checking bench for sparse_transpose_scatter_accumulate: directed words, then random ones.
// A column-sum tracker predicts every read word and checks it field by field.
// Depends on stsa_pkg and the block's RTL.

module tb_sparse_transpose_scatter_accumulate;

   import stsa_pkg::*;

   localparam int     COLUMNS      = COLUMNS_DEF;
   localparam int     RANDOM_WORDS = 1300;
   localparam int     QUIET_TAIL   = 200;
   localparam longint SUM_HI       = (longint'(1) << (SUM_W - 1)) - 1;
   localparam longint SUM_LO       = -(longint'(1) << (SUM_W - 1));
   localparam logic [VAL_W-1:0] ONE     = 32'h0001_0000;
   localparam logic [VAL_W-1:0] NEG_ONE = 32'hFFFF_0000;
   localparam logic [VAL_W-1:0] V_MIN   = 32'h8000_0000;
   localparam logic [VAL_W-1:0] V_MAX   = 32'h7FFF_FFFF;

   typedef struct packed {
      logic [COL_W-1:0] column;
      logic [SUM_W-1:0] sum;
      logic             overflowed;
   } readout_type;

   class column_sum_tracker_type;
      int          n_columns;
      int          failures;
      longint      column_sums[];
      bit          column_flags[];
      readout_type pending_readouts[$];

      function new(int columns);
         n_columns = columns;
         failures = 0;
         column_sums = new[columns];
         column_flags = new[columns];
         foreach (column_sums[i]) begin
            column_sums[i] = 0;
            column_flags[i] = 1'b0;
         end
      endfunction

      function int outstanding();
         return pending_readouts.size();
      endfunction

      function void note_word(op_type op, logic [COL_W-1:0] col,
                              logic signed [VAL_W-1:0] scale,
                              logic signed [VAL_W-1:0] val);
         longint      prod;
         longint      total;
         readout_type r;
         if (op == OP_ACCUMULATE) begin
            if (col >= n_columns || scale == 0) return;
            prod = (longint'(scale) * longint'(val)) >>> FRAC_W;
            total = column_sums[col] + prod;
            if (total > SUM_HI) begin
               total = SUM_HI;
               column_flags[col] = 1'b1;
            end else if (total < SUM_LO) begin
               total = SUM_LO;
               column_flags[col] = 1'b1;
            end
            column_sums[col] = total;
         end else begin
            r.column = col;
            r.sum = '0;
            r.overflowed = 1'b0;
            if (col < n_columns) begin
               r.sum = SUM_W'(column_sums[col]);
               r.overflowed = column_flags[col];
               column_sums[col] = 0;
               column_flags[col] = 1'b0;
            end
            pending_readouts = {pending_readouts, r};
         end
      endfunction

      function void check_readout(logic [COL_W-1:0] col, logic [SUM_W-1:0] sum,
                                  logic overflowed);
         readout_type e;
         if (pending_readouts.size() == 0) begin
            $error("result word with no read outstanding: read_column %0d", col);
            failures++;
            return;
         end
         e = pending_readouts.pop_front();
         if (col !== e.column) begin
            $error("read_column: expected %0d, actual %0d", e.column, col);
            failures++;
         end
         if (sum !== e.sum) begin
            $error("column_sum: expected %h, actual %h", e.sum, sum);
            failures++;
         end
         if (overflowed !== e.overflowed) begin
            $error("overflowed: expected %b, actual %b", e.overflowed, overflowed);
            failures++;
         end
      endfunction
   endclass

   logic                    clock;
   logic                    reset            = 1'b1;
   logic                    start            = 1'b0;
   logic                    busy;
   logic                    req_operation    = 1'b0;
   logic [COL_W-1:0]        req_column       = '0;
   logic signed [VAL_W-1:0] req_row_scale    = '0;
   logic signed [VAL_W-1:0] req_matrix_value = '0;
   logic                    rsp_strobe;
   logic [COL_W-1:0]        rsp_read_column;
   logic signed [SUM_W-1:0] rsp_column_sum;
   logic                    rsp_overflowed;

   column_sum_tracker_type tracker;

   sparse_transpose_scatter_accumulate #(.COLUMNS(COLUMNS)) dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_operation    (req_operation),
      .req_column       (req_column),
      .req_row_scale    (req_row_scale),
      .req_matrix_value (req_matrix_value),
      .rsp_strobe       (rsp_strobe),
      .rsp_read_column  (rsp_read_column),
      .rsp_column_sum   (rsp_column_sum),
      .rsp_overflowed   (rsp_overflowed)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (start === 1'b1 && busy === 1'b0)
            tracker.note_word(op_type'(req_operation), req_column, req_row_scale,
                              req_matrix_value);
         if (rsp_strobe !== 1'b0)
            tracker.check_readout(rsp_read_column, rsp_column_sum, rsp_overflowed);
      end
   end

   // called just after a rising edge; returns just after the edge that takes the word
   task automatic send_word(input op_type op, input logic [COL_W-1:0] col,
                            input logic [VAL_W-1:0] scale, input logic [VAL_W-1:0] val);
      start            <= 1'b1;
      req_operation    <= op;
      req_column       <= col;
      req_row_scale    <= scale;
      req_matrix_value <= val;
      do @(posedge clock); while (busy !== 1'b0);
   endtask

   task automatic pause(input int cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic drain();
      start <= 1'b0;
      do @(posedge clock); while (tracker.outstanding() != 0);
   endtask

   function automatic logic [VAL_W-1:0] random_operand();
      logic [VAL_W-1:0] r;
      r = $urandom();
      case ($urandom_range(0, 3))
         0:       return $urandom_range(0, 1) ? V_MIN : V_MAX;
         1:       return {{14{r[17]}}, r[17:0]};
         default: return r;
      endcase
   endfunction

   initial begin
      op_type           op;
      logic [COL_W-1:0] col;
      logic [COL_W-1:0] prev_col;
      logic [COL_W-1:0] hot[4];
      logic [VAL_W-1:0] scale;
      logic [VAL_W-1:0] val;

      tracker = new(COLUMNS);
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // back-to-back on one column, read straight after accumulate, read ignores operands
      send_word(OP_ACCUMULATE, 12'd0, ONE, ONE);
      send_word(OP_ACCUMULATE, 12'd0, ONE, NEG_ONE);
      send_word(OP_ACCUMULATE, 12'd0, 32'h0002_8000, 32'h0003_0000);
      send_word(OP_READ, 12'd0, 32'hDEAD_BEEF, 32'h1234_5678);
      send_word(OP_ACCUMULATE, 12'd0, ONE, ONE);
      send_word(OP_READ, 12'd0, '0, '0);
      send_word(OP_READ, 12'd0, '1, '1);
      // zero row scale
      send_word(OP_ACCUMULATE, 12'd5, '0, V_MAX);
      send_word(OP_READ, 12'd5, '0, '0);
      pause(3);
      // flooring of tiny negative products
      send_word(OP_ACCUMULATE, 12'd2, 32'h0000_0001, 32'hFFFF_FFFF);
      send_word(OP_ACCUMULATE, 12'd2, 32'hFFFF_FFFF, 32'h0000_0001);
      send_word(OP_READ, 12'd2, '0, '0);
      // positive saturation, sticky flag
      send_word(OP_ACCUMULATE, 12'd4095, V_MIN, V_MIN);
      send_word(OP_ACCUMULATE, 12'd4095, V_MIN, V_MIN);
      send_word(OP_ACCUMULATE, 12'd4095, ONE, NEG_ONE);
      send_word(OP_READ, 12'd4095, '0, '0);
      pause(1);
      // negative saturation
      send_word(OP_ACCUMULATE, 12'd1, V_MIN, V_MAX);
      send_word(OP_ACCUMULATE, 12'd1, V_MIN, V_MAX);
      send_word(OP_ACCUMULATE, 12'd1, V_MIN, V_MAX);
      send_word(OP_READ, 12'd1, '0, '0);
      send_word(OP_READ, 12'd4095, '0, '0);
      send_word(OP_READ, 12'd3000, '0, '0);
      send_word(OP_ACCUMULATE, 12'd7, V_MAX, V_MAX);
      send_word(OP_READ, 12'd7, '0, '0);
      drain();

      hot[0] = 12'd0;
      hot[1] = 12'd4095;
      hot[2] = COL_W'($urandom_range(1, 4094));
      hot[3] = COL_W'($urandom_range(1, 4094));
      prev_col = hot[2];
      for (int i = 0; i < RANDOM_WORDS; i++) begin
         if (i == RANDOM_WORDS / 2)
            drain();
         op = ($urandom_range(0, 4) == 0) ? OP_READ : OP_ACCUMULATE;
         case ($urandom_range(0, 3))
            0:       col = prev_col;
            1, 2:    col = hot[2'($urandom_range(0, 3))];
            default: col = COL_W'($urandom_range(0, 4095));
         endcase
         if ($urandom_range(0, 5) == 0) begin
            scale = V_MIN;
            val = $urandom_range(0, 1) ? V_MIN : V_MAX;
         end else begin
            scale = random_operand();
            val = random_operand();
         end
         if ($urandom_range(0, 15) == 0)
            scale = '0;
         send_word(op, col, scale, val);
         prev_col = col;
         if (i < RANDOM_WORDS - QUIET_TAIL && $urandom_range(0, 7) == 0)
            pause($urandom_range(1, 16));
      end

      drain();
      repeat (8) @(posedge clock);
      if (tracker.failures == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

/* files.f */
sv/stsa_pkg.sv
sv/stsa_ram.sv
sv/sparse_transpose_scatter_accumulate.sv
tb/sv/tb_sparse_transpose_scatter_accumulate.sv
